/* rtl/core/afc_pkg.sv */
// Package for the box frustum culler: word types, queue depths and codes.
// No dependencies; every other file of the block but afc_fifo imports it.
`default_nettype none

package afc_pkg;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEST = 1'b1;

  localparam int COORD_W = 24;
  localparam int NORM_W  = 16;
  localparam int PIDX_W  = 3;
  localparam int IDX_W   = 16;
  localparam int THR_W   = 48;
  localparam int HALF_W  = COORD_W + 1;

  localparam logic signed [THR_W-1:0] THR_RESET = 48'sd8;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  typedef struct packed {
    logic                      req_type;
    logic [PIDX_W-1:0]         plane_index;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic signed [COORD_W-1:0] plane_offset;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } in_t;

  typedef struct packed {
    logic             visible;
    logic [IDX_W-1:0] box_index;
  } out_t;

  // front -> back word: a plane load or a box to be tested (doubled center/extent)
  typedef struct packed {
    logic                      is_load;
    logic [PIDX_W-1:0]         plane_index;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic signed [COORD_W-1:0] plane_offset;
    logic signed [HALF_W-1:0]  sum_x;
    logic signed [HALF_W-1:0]  sum_y;
    logic signed [HALF_W-1:0]  sum_z;
    logic signed [HALF_W-1:0]  ext_x;
    logic signed [HALF_W-1:0]  ext_y;
    logic signed [HALF_W-1:0]  ext_z;
    logic [IDX_W-1:0]          box_index;
  } mid_t;

endpackage

`default_nettype wire

/* rtl/core/aabb_frustum_cull.sv */
// Box frustum culler: tests one box per cycle against NUM_PLANES stored planes
// while the result queue has room; a box word is accepted every cycle while the
// 4-entry front queue has room and a plane load likewise. A box passes through
// the front queue and the two back-end register stages (product stage,
// accumulate stage) into an 8-entry result queue that absorbs output stalls.
// Plane loads pass through the same queue, so they apply in order. Depends on
// afc_pkg, afc_front, afc_fifo and afc_back.
`default_nettype none

module aabb_frustum_cull
  import afc_pkg::*;
#(
  parameter int NUM_PLANES = 6
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_push,
  input  wire in_t                     in_data,
  output logic                         in_full,
  output logic                         out_empty,
  input  wire logic                    out_pop,
  output out_t                         out_data,
  input  wire logic                    cfg_we,
  input  wire logic signed [THR_W-1:0] cfg_data
);

  logic signed [THR_W-1:0] thr_r;
  logic                    mid_wr, mid_full, mid_rd, mid_empty;
  mid_t                    mid_wdata, mid_rdata;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_data;
    end
  end

  afc_front #(
    .NUM_PLANES (NUM_PLANES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .mid_wr   (mid_wr),
    .mid_data (mid_wdata),
    .mid_full (mid_full)
  );

  afc_fifo #(
    .WIDTH ($bits(mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_wr),
    .wr_data (mid_wdata),
    .full    (mid_full),
    .rd_en   (mid_rd),
    .rd_data (mid_rdata),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  afc_back #(
    .NUM_PLANES (NUM_PLANES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (thr_r),
    .mid_data  (mid_rdata),
    .mid_empty (mid_empty),
    .mid_rd    (mid_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  a_mid_count: assert property (@(posedge clk) disable iff (!rst_n)
    mid_empty == (mid_count == '0))
    else $error("front queue empty flag disagrees with count");

endmodule

`default_nettype wire

/* rtl/core/afc_fifo.sv */
// Small first-word-fall-through queue of register entries.
// Depends on nothing; used between front and back and on the result side.
`default_nettype none

module afc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [WIDTH-1:0]           wr_data,
  output logic                            full,
  input  wire logic                       rd_en,
  output logic [WIDTH-1:0]                rd_data,
  output logic                            empty,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem_r[rptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= wptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rptr_r <= rptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/afc_front.sv */
// Front end: accepts words, drops out-of-range loads, numbers boxes and
// forms doubled center and extent. Depends on afc_pkg.
`default_nettype none

module afc_front
  import afc_pkg::*;
#(
  parameter int NUM_PLANES = 6
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  input  wire in_t  in_data,
  output logic      in_full,
  output logic      mid_wr,
  output mid_t      mid_data,
  input  wire logic mid_full
);

  logic [IDX_W-1:0] box_cnt_r, box_cnt_nxt;
  logic             accept, is_load, idx_ok;

  assign in_full = mid_full;
  assign accept  = in_push && !mid_full;
  assign is_load = (in_data.req_type == REQ_LOAD);
  assign idx_ok  = ({1'b0, in_data.plane_index} < (PIDX_W+1)'(NUM_PLANES));
  assign mid_wr  = accept && (!is_load || idx_ok);

  always_comb begin
    mid_data.is_load      = is_load;
    mid_data.plane_index  = in_data.plane_index;
    mid_data.normal_x     = in_data.normal_x;
    mid_data.normal_y     = in_data.normal_y;
    mid_data.normal_z     = in_data.normal_z;
    mid_data.plane_offset = in_data.plane_offset;
    mid_data.sum_x = HALF_W'(in_data.max_x) + HALF_W'(in_data.min_x);
    mid_data.sum_y = HALF_W'(in_data.max_y) + HALF_W'(in_data.min_y);
    mid_data.sum_z = HALF_W'(in_data.max_z) + HALF_W'(in_data.min_z);
    mid_data.ext_x = HALF_W'(in_data.max_x) - HALF_W'(in_data.min_x);
    mid_data.ext_y = HALF_W'(in_data.max_y) - HALF_W'(in_data.min_y);
    mid_data.ext_z = HALF_W'(in_data.max_z) - HALF_W'(in_data.min_z);
    mid_data.box_index    = box_cnt_r;
  end

  always_comb begin
    box_cnt_nxt = box_cnt_r;
    if (accept) begin
      if (!is_load) begin
        box_cnt_nxt = box_cnt_r + IDX_W'(1);
      end else if (idx_ok) begin
        box_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_cnt_r <= '0;
    end else begin
      box_cnt_r <= box_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/afc_back.sv */
// Back end: plane store, per-plane product stage, accumulate stage and
// result queue. Depends on afc_pkg and afc_fifo.
`default_nettype none

module afc_back
  import afc_pkg::*;
#(
  parameter int NUM_PLANES = 6
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic signed [THR_W-1:0] threshold,
  input  wire mid_t                    mid_data,
  input  wire logic                    mid_empty,
  output logic                         mid_rd,
  output logic                         out_empty,
  input  wire logic                    out_pop,
  output out_t                         out_data
);

  localparam int PROD_W = NORM_W + 1 + HALF_W;
  localparam int ACC_W  = 52;
  localparam int NPROD  = 6;
  localparam int CNT_W  = $clog2(OUT_DEPTH+1);
  localparam int OFF_SH = NORM_W - 1;

  logic signed [NORM_W-1:0]  nx_r [NUM_PLANES];
  logic signed [NORM_W-1:0]  ny_r [NUM_PLANES];
  logic signed [NORM_W-1:0]  nz_r [NUM_PLANES];
  logic signed [COORD_W-1:0] off_r [NUM_PLANES];

  logic signed [PROD_W-1:0]  prod_nxt [NUM_PLANES][NPROD];
  logic signed [PROD_W-1:0]  prod_r   [NUM_PLANES][NPROD];
  logic signed [COORD_W-1:0] poff_r   [NUM_PLANES];
  logic signed [ACC_W-1:0]   acc_nxt  [NUM_PLANES];
  logic signed [ACC_W-1:0]   acc_r    [NUM_PLANES];
  logic [IDX_W-1:0]          pidx_r, aidx_r;
  logic                      vp_r, va_r;

  logic                      head_load, head_test, credit_ok;
  logic [CNT_W-1:0]          out_count;
  logic                      out_full, out_push, vis;
  logic signed [ACC_W-1:0]   thr2;
  out_t                      res;

  function automatic logic signed [NORM_W:0] abs_n(input logic signed [NORM_W-1:0] n);
    logic signed [NORM_W:0] w;
    w = (NORM_W+1)'(n);
    return n[NORM_W-1] ? -w : w;
  endfunction

  assign credit_ok = ((CNT_W+1)'(out_count) + (CNT_W+1)'(vp_r) + (CNT_W+1)'(va_r))
                     < (CNT_W+1)'(OUT_DEPTH);
  assign head_load = !mid_empty && mid_data.is_load;
  assign head_test = !mid_empty && !mid_data.is_load && credit_ok;
  assign mid_rd    = head_load || head_test;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        nx_r[p]  <= '0;
        ny_r[p]  <= '0;
        nz_r[p]  <= '0;
        off_r[p] <= '0;
      end
    end else if (head_load) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        if (mid_data.plane_index == PIDX_W'(p)) begin
          nx_r[p]  <= mid_data.normal_x;
          ny_r[p]  <= mid_data.normal_y;
          nz_r[p]  <= mid_data.normal_z;
          off_r[p] <= mid_data.plane_offset;
        end
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      prod_nxt[p][0] = PROD_W'(nx_r[p]) * PROD_W'(mid_data.sum_x);
      prod_nxt[p][1] = PROD_W'(ny_r[p]) * PROD_W'(mid_data.sum_y);
      prod_nxt[p][2] = PROD_W'(nz_r[p]) * PROD_W'(mid_data.sum_z);
      prod_nxt[p][3] = PROD_W'(abs_n(nx_r[p])) * PROD_W'(mid_data.ext_x);
      prod_nxt[p][4] = PROD_W'(abs_n(ny_r[p])) * PROD_W'(mid_data.ext_y);
      prod_nxt[p][5] = PROD_W'(abs_n(nz_r[p])) * PROD_W'(mid_data.ext_z);
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      acc_nxt[p] = (ACC_W'(poff_r[p]) <<< OFF_SH);
      for (int k = 0; k < NPROD; k++) begin
        acc_nxt[p] = acc_nxt[p] + ACC_W'(prod_r[p][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      va_r <= 1'b0;
    end else begin
      vp_r <= head_test;
      va_r <= vp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (head_test) begin
      prod_r <= prod_nxt;
      poff_r <= off_r;
      pidx_r <= mid_data.box_index;
    end
    if (vp_r) begin
      acc_r  <= acc_nxt;
      aidx_r <= pidx_r;
    end
  end

  assign thr2 = ACC_W'(threshold) <<< 1;

  always_comb begin
    vis = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (acc_r[p] < thr2) begin
        vis = 1'b0;
      end
    end
  end

  assign res.visible   = vis;
  assign res.box_index = aidx_r;
  assign out_push      = va_r;

  afc_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (out_push),
    .wr_data (res),
    .full    (out_full),
    .rd_en   (out_pop),
    .rd_data (out_data),
    .empty   (out_empty),
    .count   (out_count)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("result queue written while full");

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |-> $past(vp_r))
    else $error("accumulate stage valid without product stage");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    ((CNT_W+1)'(out_count) + (CNT_W+1)'(vp_r) + (CNT_W+1)'(va_r))
      <= (CNT_W+1)'(OUT_DEPTH))
    else $error("boxes in flight exceed result queue space");

endmodule

`default_nettype wire

/* test/aabb_frustum_cull_chk.sv */
// Checker for the box frustum culler: watches the input, result and threshold ports,
// keeps its own copy of the planes and box count, and compares every result word.
// Depends on afc_pkg; instantiated beside the block by aabb_frustum_cull_tb.
module aabb_frustum_cull_chk
  import afc_pkg::*;
#(
  parameter int NUM_PLANES = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  in_t                     in_data,
  input  logic                    in_full,
  input  logic                    out_empty,
  input  logic                    out_pop,
  input  out_t                    out_data,
  input  logic                    cfg_we,
  input  logic signed [THR_W-1:0] cfg_data,
  output int                      errors,
  output int                      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [NORM_W-1:0]  nrm_x [NUM_PLANES];
  logic signed [NORM_W-1:0]  nrm_y [NUM_PLANES];
  logic signed [NORM_W-1:0]  nrm_z [NUM_PLANES];
  logic signed [COORD_W-1:0] pl_off [NUM_PLANES];
  logic [IDX_W-1:0]          box_cnt;
  logic signed [THR_W-1:0]   thr;
  out_t                      verdicts [$];
  int                        err_cnt = 0;

  // doubled form keeps the half-unit center and extent exact
  function automatic logic box_passes(in_t w);
    longint sum2 [3];
    longint ext2 [3];
    longint n [3];
    longint acc;
    longint thr2;
    logic   pass;
    sum2[0] = longint'($signed(w.max_x)) + longint'($signed(w.min_x));
    sum2[1] = longint'($signed(w.max_y)) + longint'($signed(w.min_y));
    sum2[2] = longint'($signed(w.max_z)) + longint'($signed(w.min_z));
    ext2[0] = longint'($signed(w.max_x)) - longint'($signed(w.min_x));
    ext2[1] = longint'($signed(w.max_y)) - longint'($signed(w.min_y));
    ext2[2] = longint'($signed(w.max_z)) - longint'($signed(w.min_z));
    thr2 = longint'(thr) * 2;
    pass = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      n[0] = longint'(nrm_x[p]);
      n[1] = longint'(nrm_y[p]);
      n[2] = longint'(nrm_z[p]);
      acc = longint'(pl_off[p]) * 32768;
      for (int a = 0; a < 3; a++) begin
        acc += n[a] * sum2[a] + ((n[a] < 0) ? -n[a] : n[a]) * ext2[a];
      end
      if (acc < thr2) pass = 1'b0;
    end
    return pass;
  endfunction

  always @(posedge clk) begin
    out_t want;
    out_t got;
    if (!rst_n) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        nrm_x[p] = '0;
        nrm_y[p] = '0;
        nrm_z[p] = '0;
        pl_off[p] = '0;
      end
      box_cnt = '0;
      thr = THR_RESET;
      verdicts.delete();
    end else begin
      if (cfg_we) thr = cfg_data;
      if (out_pop && !out_empty) begin
        got = out_data;
        if (verdicts.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result word: visible %0b box_index %0d",
                   $time, got.visible, got.box_index);
        end else begin
          want = verdicts.pop_front();
          if (got.visible !== want.visible) begin
            err_cnt++;
            $display("%0t: visible expected %0b actual %0b (box %0d)",
                     $time, want.visible, got.visible, want.box_index);
          end
          if (got.box_index !== want.box_index) begin
            err_cnt++;
            $display("%0t: box_index expected %0d actual %0d",
                     $time, want.box_index, got.box_index);
          end
        end
      end
      if (in_push && !in_full) begin
        if (in_data.req_type == REQ_LOAD) begin
          if (in_data.plane_index < NUM_PLANES) begin
            nrm_x[in_data.plane_index] = in_data.normal_x;
            nrm_y[in_data.plane_index] = in_data.normal_y;
            nrm_z[in_data.plane_index] = in_data.normal_z;
            pl_off[in_data.plane_index] = in_data.plane_offset;
            box_cnt = '0;
          end
        end else begin
          want.visible = box_passes(in_data);
          want.box_index = box_cnt;
          verdicts.insert(verdicts.size(), want);
          box_cnt = box_cnt + IDX_W'(1);
        end
      end
    end
    outstanding <= verdicts.size();
    errors <= err_cnt;
  end

endmodule

/* test/aabb_frustum_cull_tb.sv */
// Testbench top for the box frustum culler: clock, reset, plane/box stimulus,
// threshold writes and random stalls on both queues; checking is in aabb_frustum_cull_chk.
// Depends on afc_pkg, aabb_frustum_cull and aabb_frustum_cull_chk.
module aabb_frustum_cull_tb;
  import afc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PLANES  = 6;
  localparam int CMIN        = -8388608;
  localparam int CMAX        = 8388607;
  localparam int NMIN        = -32768;
  localparam int NMAX        = 32767;
  localparam int HOLD_CYCLES = 80;
  localparam int LAT_WAIT    = 8;
  localparam int WATCHDOG    = 2000;
  localparam int PHASE_WORDS = 160;

  localparam logic signed [THR_W-1:0] THR_MIN = {1'b1, {(THR_W-1){1'b0}}};
  localparam logic signed [THR_W-1:0] THR_MAX = {1'b0, {(THR_W-1){1'b1}}};

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_push = 1'b0;
  in_t                     in_data = '0;
  logic                    in_full;
  logic                    out_empty;
  logic                    out_pop = 1'b0;
  out_t                    out_data;
  logic                    cfg_we = 1'b0;
  logic signed [THR_W-1:0] cfg_data = '0;
  int                      errors;
  int                      outstanding;

  int snd_max = 7;
  int rcv_max = 7;
  int hold_req = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  aabb_frustum_cull #(.NUM_PLANES(NUM_PLANES)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  aabb_frustum_cull_chk #(.NUM_PLANES(NUM_PLANES)) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_data    (in_data),
    .in_full    (in_full),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .outstanding(outstanding)
  );

  function automatic in_t noise_word();
    logic [223:0] bits;
    in_t          w;
    bits = {$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom()};
    w = bits[$bits(in_t)-1:0];
    return w;
  endfunction

  // unused plane fields stay random on a test word
  function automatic in_t make_test(int lx, int ly, int lz, int hx, int hy, int hz);
    in_t w;
    w = noise_word();
    w.req_type = REQ_TEST;
    w.min_x = COORD_W'(lx);
    w.min_y = COORD_W'(ly);
    w.min_z = COORD_W'(lz);
    w.max_x = COORD_W'(hx);
    w.max_y = COORD_W'(hy);
    w.max_z = COORD_W'(hz);
    return w;
  endfunction

  function automatic in_t make_load(int idx, int nx, int ny, int nz, int d);
    in_t w;
    w = noise_word();
    w.req_type = REQ_LOAD;
    w.plane_index = PIDX_W'(idx);
    w.normal_x = NORM_W'(nx);
    w.normal_y = NORM_W'(ny);
    w.normal_z = NORM_W'(nz);
    w.plane_offset = COORD_W'(d);
    return w;
  endfunction

  // planes biased toward passing so that visible and culled boxes both show up
  function automatic in_t rand_plane(int idx);
    return make_load(idx, int'($urandom_range(0, 32768)) - 16384,
                     int'($urandom_range(0, 32768)) - 16384,
                     int'($urandom_range(0, 32768)) - 16384,
                     int'($urandom_range(0, 8192)) - 2048);
  endfunction

  function automatic in_t rand_box();
    int  cx, cy, cz, hx, hy, hz;
    in_t w;
    cx = int'($urandom_range(0, 8192)) - 4096;
    cy = int'($urandom_range(0, 8192)) - 4096;
    cz = int'($urandom_range(0, 8192)) - 4096;
    hx = $urandom_range(0, 1024);
    hy = $urandom_range(0, 1024);
    hz = $urandom_range(0, 1024);
    w = make_test(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
    if ($urandom_range(0, 15) == 0) {w.min_x, w.max_x} = {w.max_x, w.min_x};
    return w;
  endfunction

  // push stays high between back-to-back words
  task automatic send_word(input in_t w);
    int gap;
    gap = $urandom_range(0, snd_max);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_full !== 1'b0);
  endtask

  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  task automatic write_thr(input logic signed [THR_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_frustum();
    for (int p = 0; p < NUM_PLANES; p++) send_word(rand_plane(p));
  endtask

  initial begin : rcv
    int w;
    int hold_seen;
    hold_seen = 0;
    forever begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      w = $urandom_range(0, rcv_max);
      if (w != 0) begin
        out_pop <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty !== 1'b0);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle = 0;
      else idle++;
      if (idle >= WATCHDOG) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stim
    logic signed [THR_W-1:0] thr_set [5];
    int                      r;
    logic [63:0]             rbits;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // planes still zero: everything culled at the reset threshold
    send_word(make_test(-256, -256, -256, 256, 256, 256));
    send_word(make_test(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    // out-of-range plane loads must change nothing, box count included
    send_word(make_load(6, NMAX, NMAX, NMAX, CMAX));
    send_word(make_load(7, NMIN, NMIN, NMIN, CMIN));
    send_word(make_test(0, 0, 0, 0, 0, 0));
    // unit cube frustum
    send_word(make_load(0, 16384, 0, 0, 256));
    send_word(make_load(1, -16384, 0, 0, 256));
    send_word(make_load(2, 0, 16384, 0, 256));
    send_word(make_load(3, 0, -16384, 0, 256));
    send_word(make_load(4, 0, 0, 16384, 256));
    send_word(make_load(5, 0, 0, -16384, 256));
    send_word(make_test(-64, -64, -64, 64, 64, 64));
    send_word(make_test(1024, 1024, 1024, 2048, 2048, 2048));
    send_word(make_test(128, -64, -64, -128, 64, 64));
    send_word(make_test(512, 0, 0, 300, 0, 0));
    send_word(make_test(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    send_word(make_load(0, NMIN, NMAX, NMIN, CMIN));
    send_word(make_load(1, NMAX, NMIN, NMAX, CMAX));
    send_word(make_test(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    send_word(make_test(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send_word(make_test(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    send_word(make_test(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX));
    settle();

    rbits = {$urandom(), $urandom()};
    thr_set[0] = '0;
    thr_set[1] = THR_W'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
    thr_set[2] = THR_MIN;
    thr_set[3] = THR_MAX;
    thr_set[4] = rbits[THR_W-1:0];

    for (int ph = 0; ph < 5; ph++) begin
      write_thr(thr_set[ph]);
      snd_max = (ph == 3) ? 0 : 7;
      rcv_max = (ph == 3) ? 0 : 7;
      load_frustum();
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (ph == 1 && i == 20) begin
          snd_max = 0;
          hold_req++;
        end
        if (ph == 1 && i == 60) snd_max = 7;
        r = $urandom_range(0, 99);
        if (r < 82) send_word(rand_box());
        else if (r < 88) send_word(rand_plane($urandom_range(0, NUM_PLANES - 1)));
        else send_word(noise_word());
      end
      settle();
    end

    if (errors == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
